// File: hdl/pqs_pkg.sv
// shared types and constants for the port queue priority scheduler
`timescale 1ns / 1ps
`default_nettype none

package pqs_pkg;

    // field widths of the words on both channels
    localparam int PORT_W      = 3;
    localparam int PRIO_W      = 8;
    localparam int PAYLOAD_W   = 32;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;

    // configuration register widths and indexes
    localparam int CFG_PORTS_W = 4;
    localparam int CFG_LIMIT_W = 5;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0]   CFG_IDX_PORTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0]   CFG_IDX_LIMIT = 1'b1;

    localparam logic [CFG_PORTS_W-1:0] RESET_PORTS   = 4'd8;
    localparam logic [CFG_LIMIT_W-1:0] RESET_LIMIT   = 5'd16;

    // request codes
    localparam logic REQ_RECEIVE = 1'b0;
    localparam logic REQ_ROUND   = 1'b1;

    // result kind codes
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PACKET = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

    // receive status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PORT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd2;

    typedef struct packed {
        logic                 req_type;
        logic [PORT_W-1:0]    port;
        logic [PRIO_W-1:0]    prio;
        logic [PAYLOAD_W-1:0] payload_tag;
    } in_word_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [STATUS_W-1:0]  status;
        logic [PORT_W-1:0]    out_port;
        logic [PRIO_W-1:0]    out_prio;
        logic [PAYLOAD_W-1:0] out_payload;
        logic                 last;
    } out_word_t;

    // one queued packet descriptor
    typedef struct packed {
        logic [PRIO_W-1:0]    prio;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic recv;
        logic scan_step;
        logic emit_pkt;
        logic emit_empty;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_is_round;
        logic scan_last;
        logic round_empty;
        logic out_free;
        logic pkt_last;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/pqs_ctrl.sv
// controller state machine: sequences receive, scan, sort drain and emission
`timescale 1ns / 1ps
`default_nettype none

module pqs_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire pqs_pkg::dp_status_t status,
    output pqs_pkg::ctrl_cmd_t      cmd
);
    import pqs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RECV  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_EMIT  = 6'b010000,
        S_EMPTY = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // input side is open only between items
    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.in_is_round ? S_SCAN : S_RECV;
                end
            end
            S_RECV:
            begin
                if (status.out_free)
                begin
                    cmd.recv   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = status.round_empty ? S_EMPTY : S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_pkt = 1'b1;
                    if (status.pkt_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // an accepted word always starts work
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted word did not start work");

endmodule

`default_nettype wire

// File: hdl/pqs_sorter.sv
// insertion sorter holding one round's port heads, highest priority in cell 0
`timescale 1ns / 1ps
`default_nettype none

module pqs_sorter #(
    parameter int PORT_COUNT = 8,
    parameter int PIW        = 3
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             clear,
    input  wire logic             ins_valid,
    input  wire pqs_pkg::entry_t  ins_entry,
    input  wire logic [PIW-1:0]   ins_port,
    input  wire logic             shift,
    output pqs_pkg::entry_t       head_entry,
    output logic [PIW-1:0]        head_port,
    output logic                  head_valid,
    output logic                  next_valid
);
    import pqs_pkg::*;

    logic           valid_reg  [PORT_COUNT];
    logic           valid_next [PORT_COUNT];
    entry_t         ent_reg    [PORT_COUNT];
    entry_t         ent_next   [PORT_COUNT];
    logic [PIW-1:0] port_reg   [PORT_COUNT];
    logic [PIW-1:0] port_next  [PORT_COUNT];

    // neighbor views: the cell above for insertion, the cell below for shifting
    logic           ge         [PORT_COUNT];
    logic           ge_ext     [PORT_COUNT+1];
    logic           prev_valid [PORT_COUNT];
    entry_t         prev_ent   [PORT_COUNT];
    logic [PIW-1:0] prev_port  [PORT_COUNT];
    logic           below_valid[PORT_COUNT];
    entry_t         below_ent  [PORT_COUNT];
    logic [PIW-1:0] below_port [PORT_COUNT];

    // neighbor wiring; cells stay sorted so ge is a prefix of ones
    always_comb
    begin
        ge_ext[0]     = 1'b1;
        prev_valid[0] = 1'b1;
        prev_ent[0]   = ins_entry;
        prev_port[0]  = ins_port;
        for (int j = 0; j < PORT_COUNT; j++)
        begin
            ge[j]       = valid_reg[j] && (ent_reg[j].prio >= ins_entry.prio);
            ge_ext[j+1] = ge[j];
        end
        for (int j = 1; j < PORT_COUNT; j++)
        begin
            prev_valid[j] = valid_reg[j-1];
            prev_ent[j]   = ent_reg[j-1];
            prev_port[j]  = port_reg[j-1];
        end
        for (int j = 0; j < PORT_COUNT - 1; j++)
        begin
            below_valid[j] = valid_reg[j+1];
            below_ent[j]   = ent_reg[j+1];
            below_port[j]  = port_reg[j+1];
        end
        below_valid[PORT_COUNT-1] = 1'b0;
        below_ent[PORT_COUNT-1]   = ent_reg[PORT_COUNT-1];
        below_port[PORT_COUNT-1]  = port_reg[PORT_COUNT-1];
    end

    // per cell update: insert keeps equal priorities ahead of the newcomer
    always_comb
    begin
        for (int j = 0; j < PORT_COUNT; j++)
        begin
            valid_next[j] = valid_reg[j];
            ent_next[j]   = ent_reg[j];
            port_next[j]  = port_reg[j];
            priority if (clear)
            begin
                valid_next[j] = 1'b0;
            end
            else if (ins_valid)
            begin
                if (!ge[j])
                begin
                    if (ge_ext[j])
                    begin
                        valid_next[j] = 1'b1;
                        ent_next[j]   = ins_entry;
                        port_next[j]  = ins_port;
                    end
                    else
                    begin
                        valid_next[j] = prev_valid[j];
                        ent_next[j]   = prev_ent[j];
                        port_next[j]  = prev_port[j];
                    end
                end
            end
            else if (shift)
            begin
                valid_next[j] = below_valid[j];
                ent_next[j]   = below_ent[j];
                port_next[j]  = below_port[j];
            end
        end
    end

    // cell occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < PORT_COUNT; j++)
            begin
                valid_reg[j] <= 1'b0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // cell contents
    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        port_reg <= port_next;
    end

    assign head_entry = ent_reg[0];
    assign head_port  = port_reg[0];
    assign head_valid = valid_reg[0];
    assign next_valid = below_valid[0];

endmodule

`default_nettype wire

// File: hdl/pqs_datapath.sv
// datapath: config registers, queue store, queue pointers, sorter, output register
`timescale 1ns / 1ps
`default_nettype none

module pqs_datapath #(
    parameter int PORT_COUNT  = 8,
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire pqs_pkg::in_word_t                      in_word,
    output pqs_pkg::out_word_t                          out_word,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    input  wire logic                                   cfg_we,
    input  wire logic [pqs_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [pqs_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  wire pqs_pkg::ctrl_cmd_t                     cmd,
    output pqs_pkg::dp_status_t                         status
);
    import pqs_pkg::*;

    localparam int PIW   = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int QIW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW  = $clog2(QUEUE_DEPTH + 1);
    localparam int NPW   = $clog2(PORT_COUNT + 1);
    localparam int AW    = (NPW > CFG_PORTS_W) ? NPW : CFG_PORTS_W;
    localparam int LW    = (CNTW > CFG_LIMIT_W) ? CNTW : CFG_LIMIT_W;
    localparam int MAW   = PIW + QIW;
    localparam int MEM_N = 2 ** MAW;

    // wrap a queue pointer
    function automatic logic [QIW-1:0] q_incr(input logic [QIW-1:0] p);
        logic [QIW-1:0] r;
        if (p == QIW'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    logic [CFG_PORTS_W-1:0] ports_reg;
    logic [CFG_LIMIT_W-1:0] limit_reg;
    in_word_t               item_reg;

    logic [QIW-1:0]  head_reg  [PORT_COUNT];
    logic [QIW-1:0]  head_next [PORT_COUNT];
    logic [QIW-1:0]  tail_reg  [PORT_COUNT];
    logic [QIW-1:0]  tail_next [PORT_COUNT];
    logic [CNTW-1:0] cnt_reg   [PORT_COUNT];
    logic [CNTW-1:0] cnt_next  [PORT_COUNT];

    logic [PIW-1:0]  scan_reg;
    logic [PIW-1:0]  scan_next;
    logic            rd_pend_reg;
    logic [PIW-1:0]  rd_port_reg;
    entry_t          rd_data_reg;
    entry_t          mem [MEM_N];

    logic            out_valid_reg;
    logic            out_valid_next;
    out_word_t       out_word_reg;
    out_word_t       out_word_next;

    logic [AW-1:0]   active_ports;
    logic [LW-1:0]   active_limit;
    logic [PIW-1:0]  recv_pidx;
    logic            recv_port_ok;
    logic            recv_full;
    logic            recv_write;
    logic            scan_active;
    logic            scan_pop;
    logic            out_free;
    logic            out_load;

    entry_t          head_entry;
    logic [PIW-1:0]  head_port;
    logic            head_valid;
    logic            next_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ports_reg <= RESET_PORTS;
            limit_reg <= RESET_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDX_PORTS: ports_reg <= cfg_data[CFG_PORTS_W-1:0];
                CFG_IDX_LIMIT: limit_reg <= cfg_data[CFG_LIMIT_W-1:0];
                default:       ports_reg <= ports_reg;
            endcase
        end
    end

    // clamp the configured port count and limit to the built sizes
    assign active_ports = (AW'(ports_reg) > AW'(PORT_COUNT)) ? AW'(PORT_COUNT)
                                                             : AW'(ports_reg);
    assign active_limit = (LW'(limit_reg) > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH)
                                                              : LW'(limit_reg);

    // latched request word
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= in_word;
        end
    end

    // receive checks
    assign recv_pidx    = PIW'(item_reg.port);
    assign recv_port_ok = AW'(item_reg.port) < active_ports;
    assign recv_full    = LW'(cnt_reg[recv_pidx]) >= active_limit;
    assign recv_write   = cmd.recv && recv_port_ok && !recv_full;

    // scan pops the head of each active non-empty port
    assign scan_active = (AW'(scan_reg) < active_ports) && (cnt_reg[scan_reg] != '0);
    assign scan_pop    = cmd.scan_step && scan_active;
    assign scan_next   = cmd.scan_step
                       ? ((scan_reg == PIW'(PORT_COUNT - 1)) ? '0 : scan_reg + 1'b1)
                       : scan_reg;

    // queue pointer and fill count updates
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (recv_write)
        begin
            tail_next[recv_pidx] = q_incr(tail_reg[recv_pidx]);
            cnt_next[recv_pidx]  = cnt_reg[recv_pidx] + 1'b1;
        end
        if (scan_pop)
        begin
            head_next[scan_reg] = q_incr(head_reg[scan_reg]);
            cnt_next[scan_reg]  = cnt_reg[scan_reg] - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORT_COUNT; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            scan_reg    <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cnt_reg     <= cnt_next;
            scan_reg    <= scan_next;
            rd_pend_reg <= scan_pop;
        end
    end

    // queue store: write on receive, registered read on scan
    always_ff @(posedge clk)
    begin
        if (recv_write)
        begin
            mem[{recv_pidx, tail_reg[recv_pidx]}] <= '{prio: item_reg.prio,
                                                       payload: item_reg.payload_tag};
        end
        if (scan_pop)
        begin
            rd_data_reg <= mem[{scan_reg, head_reg[scan_reg]}];
            rd_port_reg <= scan_reg;
        end
    end

    // order the round's heads
    pqs_sorter #(
        .PORT_COUNT (PORT_COUNT),
        .PIW        (PIW)
    ) u_sorter (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (cmd.accept),
        .ins_valid  (rd_pend_reg),
        .ins_entry  (rd_data_reg),
        .ins_port   (rd_port_reg),
        .shift      (cmd.emit_pkt),
        .head_entry (head_entry),
        .head_port  (head_port),
        .head_valid (head_valid),
        .next_valid (next_valid)
    );

    // output register
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = cmd.recv || cmd.emit_pkt || cmd.emit_empty;

    always_comb
    begin
        out_word_next = out_word_reg;
        priority if (cmd.recv)
        begin
            out_word_next.kind        = KIND_STATUS;
            out_word_next.out_port    = item_reg.port;
            out_word_next.out_prio    = '0;
            out_word_next.out_payload = '0;
            out_word_next.last        = 1'b1;
            priority if (!recv_port_ok)
            begin
                out_word_next.status = ST_BAD_PORT;
            end
            else if (recv_full)
            begin
                out_word_next.status = ST_DROPPED;
            end
            else
            begin
                out_word_next.status = ST_ACCEPTED;
            end
        end
        else if (cmd.emit_pkt)
        begin
            out_word_next.kind        = KIND_PACKET;
            out_word_next.status      = ST_ACCEPTED;
            out_word_next.out_port    = PORT_W'(head_port);
            out_word_next.out_prio    = head_entry.prio;
            out_word_next.out_payload = head_entry.payload;
            out_word_next.last        = !next_valid;
        end
        else if (cmd.emit_empty)
        begin
            out_word_next.kind        = KIND_EMPTY;
            out_word_next.status      = ST_ACCEPTED;
            out_word_next.out_port    = '0;
            out_word_next.out_prio    = '0;
            out_word_next.out_payload = '0;
            out_word_next.last        = 1'b1;
        end
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // status back to the controller
    assign status.in_is_round = (in_word.req_type == REQ_ROUND);
    assign status.scan_last   = (scan_reg == PIW'(PORT_COUNT - 1));
    assign status.round_empty = !head_valid && !rd_pend_reg;
    assign status.out_free    = out_free;
    assign status.pkt_last    = !next_valid;

    // a held word is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output word overwritten while stalled");

    // packets are only emitted from a filled sorter
    a_emit_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_pkt |-> head_valid)
        else $error("packet emitted from empty sorter");

    // an empty round really found nothing
    a_empty_round: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_empty |-> (!head_valid && !rd_pend_reg))
        else $error("empty round reported with heads pending");

    // the final packet of a round drains the sorter
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_pkt && !next_valid) |=> !head_valid)
        else $error("sorter not empty after last packet");

endmodule

`default_nettype wire

// File: hdl/port_queue_priority_scheduler_core.sv
// Per-port tail-drop queues with a strict-priority service round.
// Receive word: accept, then queue update and status once the output register is free.
// Service round: scan every port's head through the registered store read and
//   insertion sorter, then one result word per cycle while the output is not stalled.
// Requests are handled one at a time; the input stalls until the current one is done.
// Reset clears queue pointers, fill counts and control; ports_in_use 8, queue_limit 16.
`timescale 1ns / 1ps
`default_nettype none

module port_queue_priority_scheduler_core #(
    parameter int PORT_COUNT  = 8,
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire pqs_pkg::in_word_t                  in_word,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output pqs_pkg::out_word_t                      out_word,
    input  wire logic                               cfg_we,
    input  wire logic [pqs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pqs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pqs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencing
    pqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // queues, sorter and output register
    pqs_datapath #(
        .PORT_COUNT  (PORT_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .out_word  (out_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// File: dv/port_queue_priority_scheduler_core_test.sv
// testbench for the port queue priority scheduler: random and directed words, scoreboard
`timescale 1ns / 1ps

module port_queue_priority_scheduler_core_test;

    import pqs_pkg::*;

    localparam int PORT_COUNT  = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int SQUEEZE_LEN = 300;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_word_t              in_word = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_word_t             out_word;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_IDX_PORTS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // words waiting to be offered and result words still owed by the block
    in_word_t  offered_words[$];
    out_word_t due_results[$];

    // shadow of the per-port queues and registers
    entry_t                  held_entry[PORT_COUNT][QUEUE_DEPTH];
    int                      held_head[PORT_COUNT];
    int                      held_count[PORT_COUNT];
    logic [CFG_PORTS_W-1:0]  cur_ports = RESET_PORTS;
    logic [CFG_LIMIT_W-1:0]  cur_limit = RESET_LIMIT;

    int error_count = 0;
    int quiet_cycles = 0;
    bit gaps_on = 1'b1;
    int hold_req = 0;
    bit word_taken = 1'b0;

    port_queue_priority_scheduler_core #(
        .PORT_COUNT  (PORT_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    // enqueue or serve one request word against the shadow queues
    task automatic apply_request(input in_word_t w);
        out_word_t r;
        entry_t    e;
        entry_t    sort_entry[PORT_COUNT];
        logic [PORT_W-1:0] sort_port[PORT_COUNT];
        int active;
        int lim;
        int n;
        int j;
        active = (cur_ports > PORT_COUNT) ? PORT_COUNT : int'(cur_ports);
        lim = (cur_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(cur_limit);
        r = '0;
        r.last = 1'b1;
        if (w.req_type == REQ_RECEIVE)
        begin
            r.kind = KIND_STATUS;
            r.out_port = w.port;
            if (w.port >= active)
                r.status = ST_BAD_PORT;
            else if (held_count[w.port] >= lim)
                r.status = ST_DROPPED;
            else
            begin
                held_entry[w.port][(held_head[w.port] + held_count[w.port]) % QUEUE_DEPTH] =
                    '{prio: w.prio, payload: w.payload_tag};
                held_count[w.port]++;
                r.status = ST_ACCEPTED;
            end
            due_results.push_back(r);
        end
        else
        begin
            // pop every active head, stable insert so ties keep the lower port first
            n = 0;
            for (int i = 0; i < PORT_COUNT; i++)
            begin
                if (i < active && held_count[i] != 0)
                begin
                    e = held_entry[i][held_head[i]];
                    held_head[i] = (held_head[i] + 1) % QUEUE_DEPTH;
                    held_count[i]--;
                    j = n;
                    while (j > 0 && sort_entry[j-1].prio < e.prio)
                    begin
                        sort_entry[j] = sort_entry[j-1];
                        sort_port[j] = sort_port[j-1];
                        j--;
                    end
                    sort_entry[j] = e;
                    sort_port[j] = i[PORT_W-1:0];
                    n++;
                end
            end
            if (n == 0)
            begin
                r.kind = KIND_EMPTY;
                due_results.push_back(r);
            end
            for (int k = 0; k < n; k++)
            begin
                r = '0;
                r.kind = KIND_PACKET;
                r.status = ST_ACCEPTED;
                r.out_port = sort_port[k];
                r.out_prio = sort_entry[k].prio;
                r.out_payload = sort_entry[k].payload;
                r.last = (k == n - 1);
                due_results.push_back(r);
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic in_word_t recv_word(input int p, input int pr, input logic [31:0] tag);
        in_word_t w;
        w.req_type = REQ_RECEIVE;
        w.port = PORT_W'(p);
        w.prio = PRIO_W'(pr);
        w.payload_tag = tag;
        return w;
    endfunction

    // random word; fields of a round word are noise
    function automatic in_word_t random_word(input int round_pct, input int port_top);
        in_word_t w;
        int r;
        w.req_type = ($urandom_range(0, 99) < round_pct) ? REQ_ROUND : REQ_RECEIVE;
        if ($urandom_range(0, 9) == 0)
            w.port = PORT_W'($urandom_range(0, 7));
        else
            w.port = PORT_W'($urandom_range(0, port_top));
        r = $urandom_range(0, 9);
        if (r == 0)
            w.prio = '0;
        else if (r == 1)
            w.prio = '1;
        else if (r < 5)
            w.prio = PRIO_W'($urandom_range(100, 103));
        else
            w.prio = PRIO_W'($urandom_range(0, 255));
        w.payload_tag = $urandom;
        return w;
    endfunction

    // input side: record accepted words and predict their results
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            apply_request(in_word);
            word_taken = 1'b1;
        end
    end

    // input driver
    always @(negedge clk)
    begin : word_driver
        logic next_valid;
        int   gap_left;
        next_valid = in_valid;
        if (rst_n)
        begin
            if (word_taken)
            begin
                word_taken = 1'b0;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (offered_words.size() != 0)
                begin
                    in_word <= offered_words.pop_front();
                    next_valid = 1'b1;
                    gap_left = pick_gap();
                end
            end
        end
        in_valid <= next_valid;
    end

    // output stall pattern, with a long hold-off on request
    always @(negedge clk)
    begin : stall_driver
        logic next_stall;
        int   stall_left;
        if (hold_req != 0)
        begin
            stall_left = hold_req;
            hold_req = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            next_stall = 1'b1;
        end
        else
        begin
            next_stall = 1'b0;
            stall_left = pick_gap();
        end
        out_stall <= next_stall;
    end

    // output side: compare each result word with the oldest owed one
    always @(posedge clk)
    begin : result_check
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
                flag_error($sformatf("result word %h with nothing owed", out_word));
            else
            begin
                want = due_results.pop_front();
                if (out_word.kind !== want.kind)
                    flag_error($sformatf("kind %0d, expected %0d", out_word.kind, want.kind));
                if (out_word.status !== want.status)
                    flag_error($sformatf("status %0d, expected %0d",
                                         out_word.status, want.status));
                if (out_word.out_port !== want.out_port)
                    flag_error($sformatf("port %0d, expected %0d",
                                         out_word.out_port, want.out_port));
                if (out_word.out_prio !== want.out_prio)
                    flag_error($sformatf("prio %0d, expected %0d",
                                         out_word.out_prio, want.out_prio));
                if (out_word.out_payload !== want.out_payload)
                    flag_error($sformatf("payload %h, expected %h",
                                         out_word.out_payload, want.out_payload));
                if (out_word.last !== want.last)
                    flag_error($sformatf("last %0d, expected %0d", out_word.last, want.last));
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            flag_error($sformatf("no handshake for %0d cycles", QUIET_LIMIT));
            $display("FAILED: results differ");
            $finish;
        end
    end

    // wait until every word is taken and every result has come back
    task automatic drain_all();
        while (offered_words.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_IDX_PORTS)
            cur_ports = val[CFG_PORTS_W-1:0];
        else
            cur_limit = val;
    endtask

    task automatic set_ports(input logic [CFG_PORTS_W-1:0] ports);
        write_reg(CFG_IDX_PORTS, {1'($urandom_range(0, 1)), ports});
    endtask

    task automatic run_phase(input logic [CFG_PORTS_W-1:0] ports,
                             input logic [CFG_LIMIT_W-1:0] limit, input int n,
                             input int round_pct, input int port_top,
                             input bit idle_on, input bit squeeze);
        drain_all();
        set_ports(ports);
        write_reg(CFG_IDX_LIMIT, limit);
        gaps_on = idle_on;
        if (squeeze)
            hold_req = SQUEEZE_LEN;
        repeat (n)
            offered_words.push_back(random_word(round_pct, port_top));
    endtask

    initial
    begin
        for (int i = 0; i < PORT_COUNT; i++)
        begin
            held_head[i] = 0;
            held_count[i] = 0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: empty round, extremes, tie on top priority, drain
        offered_words.push_back(random_word(100, 7));
        offered_words.push_back(recv_word(0, 0, 32'h0000_0000));
        offered_words.push_back(recv_word(7, 255, 32'hFFFF_FFFF));
        offered_words.push_back(recv_word(3, 255, 32'h1234_5678));
        offered_words.push_back(recv_word(5, 8'h80, 32'h0F0F_0F0F));
        offered_words.push_back(recv_word(1, 8'h55, 32'hAAAA_AAAA));
        offered_words.push_back(recv_word(2, 8'hAA, 32'h5555_5555));
        offered_words.push_back(random_word(100, 7));
        offered_words.push_back(random_word(100, 7));

        // zero limit drops, zero ports rejects and rounds come back empty
        drain_all();
        write_reg(CFG_IDX_LIMIT, 5'd0);
        offered_words.push_back(recv_word(2, 9, 32'hDEAD_0001));
        drain_all();
        write_reg(CFG_IDX_PORTS, 5'b10000);
        offered_words.push_back(recv_word(0, 9, 32'hDEAD_0002));
        offered_words.push_back(random_word(100, 7));

        // limit of one, then a lowered port count leaves port 6 parked
        drain_all();
        set_ports(4'd8);
        write_reg(CFG_IDX_LIMIT, 5'd1);
        offered_words.push_back(recv_word(6, 10, 32'hC0DE_0006));
        offered_words.push_back(recv_word(6, 11, 32'hC0DE_0007));
        offered_words.push_back(recv_word(1, 20, 32'hC0DE_0001));
        drain_all();
        set_ports(4'd3);
        offered_words.push_back(recv_word(6, 12, 32'hC0DE_0008));
        offered_words.push_back(random_word(100, 7));
        drain_all();
        set_ports(4'd15);
        offered_words.push_back(random_word(100, 7));

        // random phases over a spread of settings
        run_phase(4'd8, 5'd16, 18, 25, 7, 1'b0, 1'b0);
        run_phase(4'd15, 5'd31, 24, 5, 0, 1'b1, 1'b0);
        run_phase(4'd1, 5'd1, 18, 30, 3, 1'b1, 1'b0);
        run_phase(4'd5, 5'd4, 18, 20, 7, 1'b1, 1'b0);
        run_phase(4'd3, 5'd2, 18, 35, 7, 1'b1, 1'b0);
        run_phase(4'd9, 5'd17, 18, 25, 7, 1'b1, 1'b0);
        run_phase(4'd8, 5'd0, 18, 30, 7, 1'b1, 1'b0);
        run_phase(CFG_PORTS_W'($urandom_range(1, 8)), CFG_LIMIT_W'($urandom_range(1, 16)),
                  18, 30, 7, 1'b0, 1'b1);
        drain_all();
        repeat (30) @(posedge clk);

        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
hdl/pqs_pkg.sv
hdl/pqs_ctrl.sv
hdl/pqs_sorter.sv
hdl/pqs_datapath.sv
hdl/port_queue_priority_scheduler_core.sv
dv/port_queue_priority_scheduler_core_test.sv
